/* rtl/core/omic_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package omic_pkg;

    // Field widths of the stream items and config registers
    localparam int COORD_W = 8;
    localparam int VAL_W   = 8;
    localparam int KDIM_W  = 6;
    localparam int MDIM_W  = 9;
    localparam int CELL_W  = 7;
    localparam int REQ_W   = 2;
    localparam int CFG_IDX_W = 2;

    // Request kinds carried in tuser
    localparam logic [REQ_W-1:0] REQ_KERNEL = 2'd0;
    localparam logic [REQ_W-1:0] REQ_MAP    = 2'd1;
    localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd2;

    // Config register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_W = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_H = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_W    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_H    = 2'd3;

    localparam logic [CELL_W-1:0] CELL_HIT  = 7'd100;
    localparam logic [CELL_W-1:0] CELL_FREE = 7'd0;

    // One kernel term issued by the address sequencer
    typedef struct packed {
        logic act;   // a term is issued this cycle
        logic hit;   // its map cell lies inside the map
        logic last;  // final term of the walk
    } t_term;

endpackage

`default_nettype wire

/* rtl/core/omic_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module omic_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* rtl/core/omic_seq.sv */
`timescale 1ns / 1ps
`default_nettype none

module omic_seq #(
    parameter int KERNEL_DIM_MAX = 32,
    parameter int MAP_DIM_MAX    = 256
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_start,
    input  wire logic [omic_pkg::COORD_W-1:0]        i_col,
    input  wire logic [omic_pkg::COORD_W-1:0]        i_row,
    input  wire logic [omic_pkg::KDIM_W-1:0]         i_kw,
    input  wire logic [omic_pkg::KDIM_W-1:0]         i_kh,
    input  wire logic [omic_pkg::MDIM_W-1:0]         i_mw,
    input  wire logic [omic_pkg::MDIM_W-1:0]         i_mh,
    output omic_pkg::t_term                          o_term,
    output logic [2*((KERNEL_DIM_MAX > 1) ? $clog2(KERNEL_DIM_MAX) : 1)-1:0] o_kaddr,
    output logic [2*$clog2(MAP_DIM_MAX)-1:0]         o_maddr
);

    localparam int KIW = (KERNEL_DIM_MAX > 1) ? $clog2(KERNEL_DIM_MAX) : 1;
    localparam int MIW = $clog2(MAP_DIM_MAX);
    // map coordinate: col + kernel half span, down to -(ceil(KERNEL_DIM_MAX/2)-1)
    localparam int CW  = $clog2(256 + KERNEL_DIM_MAX) + 1;
    localparam int LW  = omic_pkg::KDIM_W + 1;

    logic                 r_run, n_run;
    logic [KIW-1:0]       r_a, n_a, r_b, n_b;
    logic signed [CW-1:0] r_mx, n_mx, r_my, n_my, r_mx0, n_mx0;
    logic                 a_last, b_last, in_map;

    assign a_last = (LW'(r_a) == (LW'(i_kw) - LW'(1)));
    assign b_last = (LW'(r_b) == (LW'(i_kh) - LW'(1)));
    assign in_map = !r_mx[CW-1] && !r_my[CW-1]
                 && ($unsigned(r_mx) < CW'(i_mw)) && ($unsigned(r_my) < CW'(i_mh));

    always_comb begin
        n_run = r_run;
        n_a   = r_a;
        n_b   = r_b;
        n_mx  = r_mx;
        n_my  = r_my;
        n_mx0 = r_mx0;
        if (i_start) begin
            n_run = 1'b1;
            n_a   = '0;
            n_b   = '0;
            n_mx0 = CW'(i_col) + CW'(i_kw[omic_pkg::KDIM_W-1:1]);
            n_mx  = CW'(i_col) + CW'(i_kw[omic_pkg::KDIM_W-1:1]);
            n_my  = CW'(i_row) + CW'(i_kh[omic_pkg::KDIM_W-1:1]);
        end else if (r_run) begin
            if (a_last) begin
                // wrap to the next kernel row
                n_a  = '0;
                n_mx = r_mx0;
                n_b  = r_b + KIW'(1);
                n_my = r_my - CW'(1);
                if (b_last) begin
                    n_run = 1'b0;
                end
            end else begin
                n_a  = r_a + KIW'(1);
                n_mx = r_mx - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
        end else begin
            r_run <= n_run;
        end
        r_a   <= n_a;
        r_b   <= n_b;
        r_mx  <= n_mx;
        r_my  <= n_my;
        r_mx0 <= n_mx0;
    end

    assign o_term.act  = r_run;
    assign o_term.hit  = r_run && in_map;
    assign o_term.last = r_run && a_last && b_last;
    assign o_kaddr     = {r_b, r_a};
    assign o_maddr     = {MIW'(r_my), MIW'(r_mx)};

endmodule

`default_nettype wire

/* rtl/core/omic_mac.sv */
`timescale 1ns / 1ps
`default_nettype none

module omic_mac #(
    parameter int KERNEL_DIM_MAX = 32
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_clear,
    input  wire omic_pkg::t_term                      i_term,
    input  wire logic signed [omic_pkg::VAL_W-1:0]    i_kdata,
    input  wire logic signed [omic_pkg::VAL_W-1:0]    i_mdata,
    output logic                                      o_busy,
    output logic signed [16+2*((KERNEL_DIM_MAX > 1) ? $clog2(KERNEL_DIM_MAX) : 1)-1:0] o_acc
);

    localparam int KIW = (KERNEL_DIM_MAX > 1) ? $clog2(KERNEL_DIM_MAX) : 1;
    localparam int PW  = 2 * omic_pkg::VAL_W;
    localparam int AW  = PW + 2 * KIW;

    logic                 r_v1, r_h1, r_v2, r_h2;
    logic signed [PW-1:0] r_prod;
    logic signed [AW-1:0] r_acc;

    // stage 1 waits on the RAM read, stage 2 holds the product
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_term.act;
            r_v2 <= r_v1;
        end
        r_h1   <= i_term.hit;
        r_h2   <= r_h1;
        r_prod <= i_kdata * i_mdata;
        if (i_clear) begin
            r_acc <= '0;
        end else if (r_v2 && r_h2) begin
            r_acc <= r_acc + AW'(r_prod);
        end
    end

    assign o_busy = r_v1 || r_v2;
    assign o_acc  = r_acc;

endmodule

`default_nettype wire

/* rtl/core/obstacle_map_inflation_convolution.sv */
// Write beats (kernel or map cell) leave the block ready after them. A query inside
// the map walks every kernel cell through the shared MAC unit, which accumulates the
// products whose map cell lies inside the map. A query outside the map skips the walk.
// Input ready stays low while a query runs, so the block takes no new request until
// the result of the last query has been handed to the output register.
// Synchronous active-low reset clears control and config; the cell stores keep no reset.
`timescale 1ns / 1ps
`default_nettype none

module obstacle_map_inflation_convolution #(
    parameter int KERNEL_DIM_MAX = 32,
    parameter int MAP_DIM_MAX    = 256
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // input stream
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire logic [23:0]                       s_axis_tdata,  // col, row, value
    input  wire logic [omic_pkg::REQ_W-1:0]        s_axis_tuser,  // req_type
    // result stream
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    output logic [7:0]                             m_axis_tdata,  // cell_value, in_range
    // config write channel
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [omic_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [omic_pkg::MDIM_W-1:0]       i_cfg_data
);

    localparam int KIW = (KERNEL_DIM_MAX > 1) ? $clog2(KERNEL_DIM_MAX) : 1;
    localparam int MIW = $clog2(MAP_DIM_MAX);
    localparam int AW  = 16 + 2 * KIW;
    localparam int KW  = omic_pkg::KDIM_W;
    localparam int MW  = omic_pkg::MDIM_W;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_WALK  = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_FIN   = 2'd3;

    // map size after reset: 256, or the store size if smaller
    localparam logic [MW-1:0] MAP_RST = (MAP_DIM_MAX < 256) ? MW'(MAP_DIM_MAX) : MW'(256);

    logic [1:0] r_state, n_state;

    logic [KW-1:0] r_kw, r_kh;
    logic [MW-1:0] r_mw, r_mh;
    logic [KW-1:0] cfg_k;
    logic [MW-1:0] cfg_m;

    logic                               in_beat;
    logic [omic_pkg::COORD_W-1:0]       in_col, in_row;
    logic [omic_pkg::VAL_W-1:0]         in_val;
    logic                               is_query, q_in_map;
    logic                               k_we, m_we;

    logic                               r_inr, n_inr;
    logic                               out_free;

    omic_pkg::t_term                    term;
    logic [2*KIW-1:0]                   kaddr;
    logic [2*MIW-1:0]                   maddr;
    logic [omic_pkg::VAL_W-1:0]         kdata, mdata;
    logic                               mac_busy;
    logic signed [AW-1:0]               acc;

    // ---------------------------------------------------------------
    // Config: clamp each dimension into [1, store size]
    // ---------------------------------------------------------------
    assign o_cfg_ready = 1'b1;

    always_comb begin
        cfg_k = i_cfg_data[KW-1:0];
        if (cfg_k == '0) begin
            cfg_k = KW'(1);
        end else if ((KW+1)'(cfg_k) > (KW+1)'(KERNEL_DIM_MAX)) begin
            cfg_k = KW'(KERNEL_DIM_MAX);
        end
        cfg_m = i_cfg_data;
        if (cfg_m == '0) begin
            cfg_m = MW'(1);
        end else if ((MW+2)'(cfg_m) > (MW+2)'(MAP_DIM_MAX)) begin
            cfg_m = MW'(MAP_DIM_MAX);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kw <= KW'(1);
            r_kh <= KW'(1);
            r_mw <= MAP_RST;
            r_mh <= MAP_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                omic_pkg::CFG_KERNEL_W: r_kw <= cfg_k;
                omic_pkg::CFG_KERNEL_H: r_kh <= cfg_k;
                omic_pkg::CFG_MAP_W:    r_mw <= cfg_m;
                omic_pkg::CFG_MAP_H:    r_mh <= cfg_m;
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Input beat decode; writes outside a store are dropped
    // ---------------------------------------------------------------
    assign s_axis_tready = (r_state == S_IDLE);
    assign in_beat  = s_axis_tvalid && s_axis_tready;
    assign in_col   = s_axis_tdata[7:0];
    assign in_row   = s_axis_tdata[15:8];
    assign in_val   = s_axis_tdata[23:16];
    assign is_query = in_beat && (s_axis_tuser == omic_pkg::REQ_QUERY);
    assign q_in_map = (MW'(in_col) < r_mw) && (MW'(in_row) < r_mh);

    assign k_we = in_beat && (s_axis_tuser == omic_pkg::REQ_KERNEL)
               && (11'(in_col) < 11'(KERNEL_DIM_MAX)) && (11'(in_row) < 11'(KERNEL_DIM_MAX));
    assign m_we = in_beat && (s_axis_tuser == omic_pkg::REQ_MAP)
               && (11'(in_col) < 11'(MAP_DIM_MAX)) && (11'(in_row) < 11'(MAP_DIM_MAX));

    // ---------------------------------------------------------------
    // Cell stores, written from the input beat, read by the sequencer
    // ---------------------------------------------------------------
    omic_ram #(
        .WIDTH (omic_pkg::VAL_W),
        .DEPTH (2 ** (2 * KIW))
    ) u_kram (
        .i_clk   (i_clk),
        .i_we    (k_we),
        .i_waddr ({in_row[KIW-1:0], in_col[KIW-1:0]}),
        .i_wdata (in_val),
        .i_raddr (kaddr),
        .o_rdata (kdata)
    );

    omic_ram #(
        .WIDTH (omic_pkg::VAL_W),
        .DEPTH (2 ** (2 * MIW))
    ) u_mram (
        .i_clk   (i_clk),
        .i_we    (m_we),
        .i_waddr ({MIW'(in_row), MIW'(in_col)}),
        .i_wdata (in_val),
        .i_raddr (maddr),
        .o_rdata (mdata)
    );

    // ---------------------------------------------------------------
    // Kernel walk and shared multiply-accumulate
    // ---------------------------------------------------------------
    omic_seq #(
        .KERNEL_DIM_MAX (KERNEL_DIM_MAX),
        .MAP_DIM_MAX    (MAP_DIM_MAX)
    ) u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (is_query && q_in_map),
        .i_col   (in_col),
        .i_row   (in_row),
        .i_kw    (r_kw),
        .i_kh    (r_kh),
        .i_mw    (r_mw),
        .i_mh    (r_mh),
        .o_term  (term),
        .o_kaddr (kaddr),
        .o_maddr (maddr)
    );

    omic_mac #(
        .KERNEL_DIM_MAX (KERNEL_DIM_MAX)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (is_query),
        .i_term  (term),
        .i_kdata (kdata),
        .i_mdata (mdata),
        .o_busy  (mac_busy),
        .o_acc   (acc)
    );

    // ---------------------------------------------------------------
    // Control: walk, drain the MAC pipe, then hand off the result
    // ---------------------------------------------------------------
    assign out_free = !m_axis_tvalid || m_axis_tready;

    always_comb begin
        n_state = r_state;
        n_inr   = r_inr;
        case (r_state)
            S_IDLE: begin
                if (is_query) begin
                    n_inr   = q_in_map;
                    n_state = q_in_map ? S_WALK : S_FIN;
                end
            end
            S_WALK: begin
                if (term.last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!mac_busy) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                // hold until the output register frees up
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            m_axis_tvalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == S_FIN) && out_free) begin
                m_axis_tvalid <= 1'b1;
            end else if (m_axis_tready) begin
                m_axis_tvalid <= 1'b0;
            end
        end
        r_inr <= n_inr;
        if ((r_state == S_FIN) && out_free) begin
            m_axis_tdata[6:0] <= (r_inr && (acc > 0)) ? omic_pkg::CELL_HIT
                                                      : omic_pkg::CELL_FREE;
            m_axis_tdata[7]   <= r_inr;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/omic_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module omic_checker (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       s_axis_tvalid,
    input wire logic                       s_axis_tready,
    input wire logic [omic_pkg::REQ_W-1:0] s_axis_tuser,
    input wire logic                       m_axis_tvalid,
    input wire logic                       m_axis_tready,
    input wire logic [7:0]                 m_axis_tdata
);

    logic s_beat;
    assign s_beat = s_axis_tvalid && s_axis_tready;

    // Result is a thresholded sum: only free or hit
    a_cell_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[6:0] == omic_pkg::CELL_FREE)
                       || (m_axis_tdata[6:0] == omic_pkg::CELL_HIT))
        else $error("cell_value neither 0 nor 100");

    // A cell outside the map never reads as inflated
    a_off_map_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tdata[7]) |-> (m_axis_tdata[6:0] == omic_pkg::CELL_FREE))
        else $error("off-map query reported an obstacle");

    // Stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result beat changed under stall");

    // A query beat occupies the block on the following cycle
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_beat && (s_axis_tuser == omic_pkg::REQ_QUERY)) |=> !s_axis_tready)
        else $error("ready after query beat");

    // Writes and unused kinds leave the block ready
    a_write_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_beat && (s_axis_tuser != omic_pkg::REQ_QUERY)) |=> s_axis_tready)
        else $error("ready dropped after non-query beat");

endmodule

bind obstacle_map_inflation_convolution omic_checker u_omic_checker (.*);

`default_nettype wire
